// ===== hw/rtl/cdq_pkg.sv =====
// Package of shared types and codes for the circular deque.
`default_nettype none
package cdq_pkg;

	localparam logic [2:0] KIND_INS_FRONT = 3'd0;
	localparam logic [2:0] KIND_INS_REAR  = 3'd1;
	localparam logic [2:0] KIND_REM_FRONT = 3'd2;
	localparam logic [2:0] KIND_REM_REAR  = 3'd3;
	localparam logic [2:0] KIND_LIST      = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] item_id;
		logic [15:0] quantity;
		logic [23:0] price;
	} command_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_item_id;
		logic [15:0] out_quantity;
		logic [23:0] out_price;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] item_id;
		logic [15:0] quantity;
		logic [23:0] price;
	} record_t;

	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_REAR,
		OP_REM_FRONT,
		OP_REM_REAR,
		OP_LIST
	} op_t;

	typedef struct packed {
		op_t     op;
		record_t rec;
	} op_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/circular_deque.sv =====
// Top level of the circular deque: front end, operation queue and back end.
//
//   channel  | direction | handshake                      | payload
//   command  | in        | start high and busy low        | cdq_pkg::command_t
//   result   | out       | result_valid high, one cycle   | cdq_pkg::result_t
//
// An insert or a rejected operation is answered straight from the idle state.
// An unused kind is dropped by the front end and never reaches the back end.
// A removal passes through the remove state because of the registered read of the record store.
// A listing streams one result per stored record from the store port.
// Busy is high while the two-entry operation queue is full; the receiver cannot stall.
// Reset empties the queue and the deque; the record store itself is not cleared.
`default_nettype none
module circular_deque #(
	parameter int DEPTH = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  cdq_pkg::command_t command,
	output logic              result_valid,
	output cdq_pkg::result_t  result
);

	cdq_pkg::queue_status_t qs;
	cdq_pkg::op_entry_t     push_entry;
	cdq_pkg::op_entry_t     head_entry;
	logic                   push;
	logic                   pop;

	cdq_front u_front (
		.start   (start),
		.command (command),
		.qs      (qs),
		.busy    (busy),
		.push    (push),
		.entry   (push_entry)
	);

	cdq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.qs         (qs)
	);

	cdq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qs           (qs),
		.entry        (head_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

	a_reject_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != cdq_pkg::ST_OK |-> result.last)
		else $error("rejected transaction not marked last");

	a_reject_no_record: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != cdq_pkg::ST_OK |->
			result.out_item_id == '0 && result.out_quantity == '0 && result.out_price == '0)
		else $error("rejected transaction carries a record");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !qs.empty)
		else $error("accepted transaction missing from operation queue");

	a_busy_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !pop || !qs.empty)
		else $error("busy with an empty operation queue");

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_front.sv =====
// Front end of the circular deque: accepts commands and classifies them into operations.
`default_nettype none
module cdq_front (
	input  wire                   start,
	input  cdq_pkg::command_t     command,
	input  cdq_pkg::queue_status_t qs,
	output logic                  busy,
	output logic                  push,
	output cdq_pkg::op_entry_t    entry
);

	logic known;

	always_comb begin
		known = 1'b1;
		entry.op = cdq_pkg::OP_LIST;
		unique case (command.kind)
			cdq_pkg::KIND_INS_FRONT: entry.op = cdq_pkg::OP_INS_FRONT;
			cdq_pkg::KIND_INS_REAR:  entry.op = cdq_pkg::OP_INS_REAR;
			cdq_pkg::KIND_REM_FRONT: entry.op = cdq_pkg::OP_REM_FRONT;
			cdq_pkg::KIND_REM_REAR:  entry.op = cdq_pkg::OP_REM_REAR;
			cdq_pkg::KIND_LIST:      entry.op = cdq_pkg::OP_LIST;
			default:                 known = 1'b0;
		endcase
		entry.rec.item_id  = command.item_id;
		entry.rec.quantity = command.quantity;
		entry.rec.price    = command.price;
	end

	// Unknown kinds are accepted and dropped here.
	assign busy = qs.full;
	assign push = start && !qs.full && known;

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_queue.sv =====
// Two-entry operation queue between the front end and the back end.
`default_nettype none
module cdq_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  cdq_pkg::op_entry_t     push_entry,
	input  wire                    pop,
	output cdq_pkg::op_entry_t     head_entry,
	output cdq_pkg::queue_status_t qs
);

	cdq_pkg::op_entry_t slot_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head_entry = slot_q[rd_ptr_q];
	assign qs.full    = count_q == 2'd2;
	assign qs.empty   = count_q == 2'd0;

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_back.sv =====
// Back end of the circular deque: record store, pointers and operation sequencer.
`default_nettype none
module cdq_back #(
	parameter int DEPTH = 8
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  cdq_pkg::queue_status_t qs,
	input  cdq_pkg::op_entry_t     entry,
	output logic                   pop,
	output logic                   result_valid,
	output cdq_pkg::result_t       result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [OW-1:0] FULL_COUNT = OW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_LIST
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [OW-1:0]    occ_q;
	logic [OW-1:0]    remain_q;
	logic [AW-1:0]    list_ptr_q;
	cdq_pkg::result_t result_q;
	logic             result_valid_q;

	cdq_pkg::record_t mem [DEPTH];
	cdq_pkg::record_t rd_data_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          is_full;
	logic          is_empty;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] p);
		prev_slot = (p == '0) ? LAST_SLOT : p - AW'(1);
	endfunction

	assign is_full  = occ_q == FULL_COUNT;
	assign is_empty = occ_q == '0;

	always_comb begin
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = tail_q;
		unique case (state_q)
			S_IDLE: begin
				if (!qs.empty) begin
					pop = 1'b1;
					unique case (entry.op)
						cdq_pkg::OP_INS_FRONT: begin
							wr_en   = !is_full;
							wr_addr = prev_slot(head_q);
						end
						cdq_pkg::OP_INS_REAR: begin
							wr_en = !is_full;
						end
						cdq_pkg::OP_REM_FRONT: begin
							rd_en = !is_empty;
						end
						cdq_pkg::OP_REM_REAR: begin
							rd_en   = !is_empty;
							rd_addr = prev_slot(tail_q);
						end
						cdq_pkg::OP_LIST: begin
							rd_en = !is_empty;
						end
						default: begin
						end
					endcase
				end
			end
			S_LIST: begin
				rd_en   = remain_q > OW'(1);
				rd_addr = list_ptr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= entry.rec;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			occ_q          <= '0;
			remain_q       <= '0;
			list_ptr_q     <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!qs.empty) begin
						result_valid_q <= 1'b1;
						result_q       <= '0;
						result_q.last  <= 1'b1;
						unique case (entry.op) inside
							cdq_pkg::OP_INS_FRONT, cdq_pkg::OP_INS_REAR: begin
								if (is_full) begin
									result_q.status <= cdq_pkg::ST_FULL;
								end else begin
									result_q.status <= cdq_pkg::ST_OK;
									occ_q <= occ_q + OW'(1);
									if (entry.op == cdq_pkg::OP_INS_FRONT) begin
										head_q <= prev_slot(head_q);
									end else begin
										tail_q <= next_slot(tail_q);
									end
								end
							end
							cdq_pkg::OP_REM_FRONT, cdq_pkg::OP_REM_REAR: begin
								if (is_empty) begin
									result_q.status <= cdq_pkg::ST_EMPTY;
								end else begin
									result_valid_q <= 1'b0;
									occ_q   <= occ_q - OW'(1);
									state_q <= S_REMOVE;
									if (entry.op == cdq_pkg::OP_REM_FRONT) begin
										head_q <= next_slot(head_q);
									end else begin
										tail_q <= prev_slot(tail_q);
									end
								end
							end
							cdq_pkg::OP_LIST: begin
								if (is_empty) begin
									result_q.status <= cdq_pkg::ST_EMPTY;
								end else begin
									result_valid_q <= 1'b0;
									remain_q   <= occ_q;
									list_ptr_q <= next_slot(head_q);
									state_q    <= S_LIST;
								end
							end
							default: begin
								result_valid_q <= 1'b0;
							end
						endcase
					end
				end
				S_REMOVE: begin
					result_valid_q        <= 1'b1;
					result_q.status       <= cdq_pkg::ST_OK;
					result_q.out_item_id  <= rd_data_q.item_id;
					result_q.out_quantity <= rd_data_q.quantity;
					result_q.out_price    <= rd_data_q.price;
					result_q.last         <= 1'b1;
					state_q               <= S_IDLE;
				end
				S_LIST: begin
					result_valid_q        <= 1'b1;
					result_q.status       <= cdq_pkg::ST_OK;
					result_q.out_item_id  <= rd_data_q.item_id;
					result_q.out_quantity <= rd_data_q.quantity;
					result_q.out_price    <= rd_data_q.price;
					result_q.last         <= remain_q == OW'(1);
					remain_q              <= remain_q - OW'(1);
					list_ptr_q            <= next_slot(list_ptr_q);
					if (remain_q == OW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire
